>>> rtl/stks_pkg.sv
// Shared types and constants of the survivor top-k selector.
package stks_pkg;

  localparam int unsigned Keep   = 32;
  localparam int unsigned IdxW   = $clog2(Keep);
  localparam int unsigned CntW   = $clog2(Keep + 1);
  localparam int unsigned FitW   = 32;
  localparam int unsigned SrcW   = 2;
  localparam int unsigned ItemW  = 8;
  localparam int unsigned SlotW  = 6;

  localparam logic [SrcW-1:0] SrcPopulation = 2'd0;
  localparam logic [SrcW-1:0] SrcInvalid    = 2'd3;

  typedef struct packed {
    logic signed [FitW-1:0] fitness;
    logic [SrcW-1:0]        source;
    logic [ItemW-1:0]       item_index;
    logic                   last;
  } in_t;

  typedef struct packed {
    logic [SlotW-1:0]       slot;
    logic [SrcW-1:0]        from_source;
    logic [ItemW-1:0]       from_index;
    logic signed [FitW-1:0] chosen_fitness;
    logic                   end_of_list;
  } out_t;

  typedef struct packed {
    logic signed [FitW-1:0] fit;
    logic [SrcW-1:0]        src;
    logic [ItemW-1:0]       idx;
  } entry_t;

  typedef struct packed {
    logic fit_lt;
    logic idx_lt;
  } cmp_t;

endpackage

>>> rtl/stks_list.sv
// Generic RAM with one write port and one registered read port.
module stks_list #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stks_cmp.sv
// Shared compare unit: signed fitness and unsigned index less-than.
module stks_cmp (
  input  logic signed [stks_pkg::FitW-1:0]  a_fit_i,
  input  logic signed [stks_pkg::FitW-1:0]  b_fit_i,
  input  logic [stks_pkg::ItemW-1:0]        a_idx_i,
  input  logic [stks_pkg::ItemW-1:0]        b_idx_i,
  output stks_pkg::cmp_t                    res_o
);
  import stks_pkg::*;

  always_comb begin
    res_o.fit_lt = (a_fit_i < b_fit_i);
    res_o.idx_lt = (a_idx_i < b_idx_i);
  end

endmodule

>>> rtl/survivor_top_k_selector.sv
// Top level of the survivor top-k selector: sequencer around the list and compare unit.
//
// Usage: present a candidate on in_i and raise start; it is taken at a clock
// edge where start is high and busy is low. Busy stays high while the block
// works on that candidate. Each candidate is placed into a list of the Keep
// best fitness values by a serial walk from the tail, one entry per cycle
// through the shared comparator; a new candidate is taken only when busy is
// low again. The list has a registered read port, so the sequencer always
// issues the next address ahead of the step that uses it. A candidate marked
// last then starts the emit if the list is not empty: population survivors
// come out in ascending index, found by repeated scans of the list (one scan
// per population survivor, each followed by its emit step, plus one empty
// scan), then offspring and mutants in list order in one more scan. Each
// result beat shows on out_o for one cycle with result_valid_o high; the
// receiver cannot stall, so nothing waits. The last beat of a round carries
// end_of_list. The list is then emptied.
// Reset (rst_ni low) empties the list and returns the sequencer to idle;
// list contents need no reset since only counted entries are ever used.
module survivor_top_k_selector (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  stks_pkg::in_t   in_i,
  output logic            busy,
  output logic            result_valid_o,
  output stks_pkg::out_t  out_o
);
  import stks_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StInsert,
    StFinish,
    StScan,
    StPopEmit,
    StOther
  } state_e;

  state_e             state_q;
  entry_t             cand_q;
  logic               last_q;
  logic [IdxW-1:0]    j_q;
  logic [IdxW-1:0]    i_q;
  logic [IdxW-1:0]    best_q;
  logic [ItemW-1:0]   best_idx_q;
  logic               found_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    k_q;
  logic [Keep-1:0]    done_q;
  logic               res_valid_q;
  out_t               res_q;

  logic               we;
  logic [IdxW-1:0]    waddr;
  entry_t             wdata;
  logic [IdxW-1:0]    raddr;
  entry_t             rdata;
  cmp_t               cmp;
  logic [ItemW-1:0]   cmp_b_idx;
  logic               scan_hit;
  logic               scan_end;
  logic               is_final;
  logic [CntW-1:0]    cnt_m1;

  stks_list #(
    .Width ($bits(entry_t)),
    .Depth (Keep)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stks_cmp u_cmp (
    .a_fit_i (rdata.fit),
    .b_fit_i (cand_q.fit),
    .a_idx_i (rdata.idx),
    .b_idx_i (cmp_b_idx),
    .res_o   (cmp)
  );

  assign cmp_b_idx = best_idx_q;
  assign cnt_m1    = cnt_q - CntW'(1);
  assign scan_end  = ({1'b0, i_q} == cnt_m1);
  assign is_final  = (k_q == cnt_m1);
  assign scan_hit  = (rdata.src == SrcPopulation) && !done_q[i_q] &&
                     (!found_q || cmp.idx_lt);

  // The read address runs one step ahead, so rdata holds the entry that the
  // current step works on.
  always_comb begin
    unique case (state_q)
      StIdle:   raddr = cnt_m1[IdxW-1:0];
      StCheck:  raddr = IdxW'(Keep - 2);
      StInsert: raddr = IdxW'(j_q - IdxW'(2));
      StScan: begin
        priority if (!scan_end) begin
          raddr = IdxW'(i_q + 1'b1);
        end else if (scan_hit) begin
          raddr = i_q;
        end else if (found_q) begin
          raddr = best_q;
        end else begin
          raddr = '0;
        end
      end
      StOther:  raddr = IdxW'(i_q + 1'b1);
      default:  raddr = '0;
    endcase
  end

  // Each walk step either moves the entry above down one place or drops the
  // candidate into the gap.
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = cand_q;
    if (state_q == StInsert) begin
      we = 1'b1;
      if (j_q != '0 && cmp.fit_lt) begin
        wdata = rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cand_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      done_q      <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      last_q      <= 1'b0;
      j_q         <= '0;
      i_q         <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            cand_q.fit <= in_i.fitness;
            cand_q.src <= in_i.source;
            cand_q.idx <= in_i.item_index;
            last_q     <= in_i.last;
            if (in_i.source == SrcInvalid) begin
              state_q <= StFinish;
            end else if (cnt_q == CntW'(Keep)) begin
              state_q <= StCheck;
            end else begin
              j_q     <= cnt_q[IdxW-1:0];
              state_q <= StInsert;
            end
          end
        end
        StCheck: begin
          // A full list takes the candidate only if it beats the tail entry.
          if (cmp.fit_lt) begin
            j_q     <= IdxW'(Keep - 1);
            state_q <= StInsert;
          end else begin
            state_q <= StFinish;
          end
        end
        StInsert: begin
          if (j_q != '0 && cmp.fit_lt) begin
            j_q <= IdxW'(j_q - 1'b1);
          end else begin
            if (cnt_q != CntW'(Keep)) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            state_q <= StFinish;
          end
        end
        StFinish: begin
          i_q     <= '0;
          k_q     <= '0;
          found_q <= 1'b0;
          if (!last_q) begin
            state_q <= StIdle;
          end else if (cnt_q == '0) begin
            state_q <= StIdle;
          end else begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (scan_hit) begin
            best_q     <= i_q;
            best_idx_q <= rdata.idx;
            found_q    <= 1'b1;
          end
          if (scan_end) begin
            i_q <= '0;
            if (found_q || scan_hit) begin
              state_q <= StPopEmit;
            end else begin
              state_q <= StOther;
            end
          end else begin
            i_q <= IdxW'(i_q + 1'b1);
          end
        end
        StPopEmit: begin
          res_valid_q          <= 1'b1;
          res_q.slot           <= SlotW'(k_q);
          res_q.from_source    <= rdata.src;
          res_q.from_index     <= rdata.idx;
          res_q.chosen_fitness <= rdata.fit;
          res_q.end_of_list    <= is_final;
          done_q[best_q]       <= 1'b1;
          k_q                  <= k_q + CntW'(1);
          found_q              <= 1'b0;
          i_q                  <= '0;
          state_q              <= StScan;
        end
        StOther: begin
          if (rdata.src != SrcPopulation) begin
            res_valid_q          <= 1'b1;
            res_q.slot           <= SlotW'(k_q);
            res_q.from_source    <= rdata.src;
            res_q.from_index     <= rdata.idx;
            res_q.chosen_fitness <= rdata.fit;
            res_q.end_of_list    <= is_final;
            k_q                  <= k_q + CntW'(1);
          end
          if (scan_end) begin
            cnt_q   <= '0;
            done_q  <= '0;
            state_q <= StIdle;
          end else begin
            i_q <= IdxW'(i_q + 1'b1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign out_o          = res_q;

endmodule

>>> tb/sv/survivor_top_k_selector_test.sv
// Self-checking testbench of the survivor top-k selector with its own ranking predictor.
`timescale 1ns / 1ps

module survivor_top_k_selector_test;
  import stks_pkg::*;

  localparam longint unsigned CycleLimit = 400000;
  localparam int unsigned     DrainCycles = 1200;
  localparam int unsigned     MaxReports = 10;

  typedef struct {
    in_t         beat;
    int unsigned idle_pct;
    bit          drain_first;
  } pending_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  in_t    in_i;
  logic   busy;
  logic   result_valid_o;
  out_t   out_o;

  pending_t        pending_q[$];
  out_t            expected_slots[$];
  entry_t          survivors[Keep];
  int unsigned     survivor_count;
  bit              beat_taken;
  int unsigned     mismatches;
  int unsigned     queued;
  longint unsigned cycles;

  survivor_top_k_selector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .in_i           (in_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .out_o          (out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Emit order of a round: population survivors by ascending index (ties stay in
  // ranked order), then offspring and mutants in ranked order.
  function automatic void release_survivors();
    bit          done[Keep];
    int          order[$];
    int          best;
    out_t        r;
    foreach (done[i]) done[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < int'(survivor_count); i++) begin
        if (survivors[i].src == SrcPopulation && !done[i] &&
            (best < 0 || survivors[i].idx < survivors[best].idx)) begin
          best = i;
        end
      end
      if (best < 0) break;
      done[best] = 1'b1;
      order.push_back(best);
    end
    for (int i = 0; i < int'(survivor_count); i++) begin
      if (survivors[i].src != SrcPopulation) order.push_back(i);
    end
    foreach (order[k]) begin
      r.slot           = SlotW'(k);
      r.from_source    = survivors[order[k]].src;
      r.from_index     = survivors[order[k]].idx;
      r.chosen_fitness = survivors[order[k]].fit;
      r.end_of_list    = (k == order.size() - 1);
      expected_slots.push_back(r);
    end
    survivor_count = 0;
  endfunction

  function automatic void rank_candidate(in_t c);
    int unsigned p;
    int unsigned j;
    p = 0;
    if (c.source != SrcInvalid) begin
      while (p < survivor_count && $signed(survivors[p].fit) >= $signed(c.fitness)) p++;
      // A full list takes the newcomer only when it beats the lowest entry outright.
      if (p < Keep) begin
        j = (survivor_count < Keep) ? survivor_count : Keep - 1;
        while (j > p) begin
          survivors[j] = survivors[j-1];
          j--;
        end
        survivors[p].fit = c.fitness;
        survivors[p].src = c.source;
        survivors[p].idx = c.item_index;
        if (survivor_count < Keep) survivor_count++;
      end
    end
    if (c.last) release_survivors();
  endfunction

  function automatic void check_slot(out_t got);
    out_t want;
    if (expected_slots.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("unexpected result beat: slot %0d src %0d idx %0d fit %0d end %0b",
                 got.slot, got.from_source, got.from_index, got.chosen_fitness,
                 got.end_of_list);
      end
    end else begin
      want = expected_slots.pop_front();
      if (got.slot !== want.slot || got.from_source !== want.from_source ||
          got.from_index !== want.from_index ||
          got.chosen_fitness !== want.chosen_fitness ||
          got.end_of_list !== want.end_of_list) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result mismatch: expected slot %0d src %0d idx %0d fit %0d end %0b",
                   want.slot, want.from_source, want.from_index, want.chosen_fitness,
                   want.end_of_list);
          $display("                 actual   slot %0d src %0d idx %0d fit %0d end %0b",
                   got.slot, got.from_source, got.from_index, got.chosen_fitness,
                   got.end_of_list);
        end
      end
    end
  endfunction

  // The sender idles 27 percent in the first stretch, 66 in the second, never after.
  function automatic void queue_candidate(logic signed [FitW-1:0] fit, logic [SrcW-1:0] src,
                                          logic [ItemW-1:0] idx, logic last, bit drain);
    pending_t p;
    p.beat.fitness    = fit;
    p.beat.source     = src;
    p.beat.item_index = idx;
    p.beat.last       = last;
    p.idle_pct        = (queued < 85) ? 27 : (queued < 170) ? 66 : 0;
    p.drain_first     = drain;
    pending_q.push_back(p);
    queued++;
  endfunction

  function automatic logic signed [FitW-1:0] pick_fitness(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic void queue_random_rounds();
    int unsigned kind;
    int unsigned size;
    int unsigned mode;
    int unsigned roll;
    bit          drain;
    logic [SrcW-1:0]  src;
    logic [ItemW-1:0] idx;
    while (queued < 220) begin
      kind  = $urandom_range(0, 9);
      size  = (kind < 2) ? $urandom_range(33, 45) : $urandom_range(1, 24);
      mode  = $urandom_range(0, 2);
      drain = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < size; n++) begin
        roll = $urandom_range(0, 99);
        if (kind == 9) begin
          // Noise round: invalid sources and out-of-range population indices.
          src = SrcW'($urandom_range(0, 3));
          idx = ItemW'($urandom_range(0, 255));
        end else begin
          src = (roll < 45) ? SrcPopulation : (roll < 70) ? 2'd1 : (roll < 95) ? 2'd2
                : SrcInvalid;
          if (src == SrcPopulation && $urandom_range(0, 99) < 85)
            idx = ItemW'($urandom_range(0, Keep - 1));
          else
            idx = ItemW'($urandom_range(0, 255));
        end
        queue_candidate(pick_fitness(mode), src, idx, n == size - 1, drain && n == 0);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) check_slot(out_o);
      if (start && !busy) begin
        beat_taken = 1'b1;
        rank_candidate(in_i);
      end
    end
  end

  always @(negedge clk_i) begin
    pending_t nxt;
    if (rst_ni) begin
      if (!start || beat_taken) begin
        beat_taken = 1'b0;
        if (pending_q.size() != 0 &&
            !(pending_q[0].drain_first && expected_slots.size() != 0) &&
            $urandom_range(0, 99) >= pending_q[0].idle_pct) begin
          nxt = pending_q.pop_front();
          in_i  <= nxt.beat;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL survivor_top_k_selector");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    in_i           = '0;
    beat_taken     = 1'b0;
    survivor_count = 0;
    mismatches     = 0;
    queued         = 0;
    cycles         = 0;

    // Empty round closed by an invalid-source beat.
    queue_candidate(32'sd0, SrcInvalid, 8'd0, 1'b1, 1'b0);
    // Extremes, ties between groups, a repeated and an out-of-range population index.
    queue_candidate(32'sh7fffffff, SrcPopulation, 8'd5, 1'b0, 1'b1);
    queue_candidate(32'sh80000000, SrcPopulation, 8'd2, 1'b0, 1'b0);
    queue_candidate(32'sd0, 2'd1, 8'd255, 1'b0, 1'b0);
    queue_candidate(32'sd0, 2'd2, 8'd0, 1'b0, 1'b0);
    queue_candidate(-32'sd1, SrcPopulation, 8'd2, 1'b0, 1'b0);
    queue_candidate(32'sd5, SrcPopulation, 8'd200, 1'b0, 1'b0);
    queue_candidate(32'sh7fffffff, SrcInvalid, 8'd7, 1'b0, 1'b0);
    queue_candidate(32'sd0, 2'd1, 8'd17, 1'b0, 1'b0);
    queue_candidate(-32'sd5, 2'd2, 8'd3, 1'b1, 1'b0);
    // One-beat round.
    queue_candidate(32'sh80000000, 2'd1, 8'd170, 1'b1, 1'b0);
    // Population only, equal fitness, repeated indices.
    queue_candidate(32'sd7, SrcPopulation, 8'd31, 1'b0, 1'b0);
    queue_candidate(32'sd7, SrcPopulation, 8'd0, 1'b0, 1'b0);
    queue_candidate(32'sd7, SrcPopulation, 8'd15, 1'b0, 1'b0);
    queue_candidate(32'sd7, SrcPopulation, 8'd0, 1'b0, 1'b0);
    queue_candidate(32'sd7, SrcPopulation, 8'd31, 1'b1, 1'b0);
    queue_random_rounds();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (pending_q.size() != 0 || start);
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_slots.size() == 0) begin
      $display("PASS survivor_top_k_selector");
    end else begin
      $display("FAIL survivor_top_k_selector");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/stks_pkg.sv
rtl/stks_list.sv
rtl/stks_cmp.sv
rtl/survivor_top_k_selector.sv
tb/sv/survivor_top_k_selector_test.sv
